FILE: src/calibrated_tick_debouncer_core_assert.svh
// assertion macros for the tick debouncer, sampled on clk_i
`ifndef CALIBRATED_TICK_DEBOUNCER_CORE_ASSERT_SVH
`define CALIBRATED_TICK_DEBOUNCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CTD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ctd assertion failed");
`define CTD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ctd assertion failed");
`else
`define CTD_ASSERT(name, prop)
`define CTD_ASSERT_ALWAYS(name, prop)
`endif
`endif

FILE: src/ctd_pkg.sv
`default_nettype none
package ctd_pkg;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_IRQ    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_THR
  } state_e;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_COUNTS = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP_MS        = 8'd1;

  localparam logic [31:0] TargetReset = 32'(40 * 1193);
  localparam logic [3:0]  GapReset    = 4'd2;
  localparam logic [15:0] CounterTop  = 16'hFFFF;
  localparam logic [7:0]  StatsPeriod = 8'd250;
  localparam logic [7:0]  StatsLast   = 8'd249;

  // divide by 40 = shift by 3, then divide by 5 one byte per step
  localparam int unsigned CalShift   = 3;
  localparam int unsigned DivSteps   = 8;
  localparam logic [11:0] Recip5     = 12'd3277;
  localparam int unsigned RecipShift = 14;

  typedef struct packed {
    logic [1:0]  pad;
    logic [5:0]  core_number;
    logic [15:0] counter_value;
    logic [63:0] stamp;
  } in_data_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [63:0] rate_value;
    logic [31:0] tick_value;
    logic        switch_due;
    logic        stats_due;
    logic        tick_taken;
    logic        eoi_only;
    logic        window_reached;
  } res_t;

  // rate times gap, saturating at all ones
  function automatic logic [63:0] sat_mul_gap(input logic [63:0] rate, input logic [3:0] gap);
    logic [67:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (gap[i]) begin
        acc = acc + (68'(rate) << i);
      end
    end
    return (acc[67:64] != 4'd0) ? '1 : acc[63:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/ctd_div40.sv
`default_nettype none
module ctd_div40 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  localparam int unsigned XW = 11;
  localparam int unsigned PW = 23;

  logic          busy_q;
  logic [2:0]    cnt_q;
  logic [63:0]   num_q;
  logic [2:0]    rem_q;
  logic [63:0]   quo_q;

  logic [XW-1:0] x;
  logic [PW-1:0] prod;
  logic [7:0]    digit;
  logic [XW-1:0] rem_full;
  logic [63:0]   quo_d;

  always_comb begin
    x        = {rem_q, num_q[63:56]};
    prod     = PW'(x) * PW'(ctd_pkg::Recip5);
    digit    = prod[ctd_pkg::RecipShift +: 8];
    // remainder stays below five
    rem_full = x - XW'({digit, 2'b00}) - XW'(digit);
    quo_d    = {quo_q[55:0], digit};
  end

  assign done_o = busy_q && (cnt_q == 3'(ctd_pkg::DivSteps - 1));
  assign quo_o  = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i >> ctd_pkg::CalShift;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 8;
      rem_q <= rem_full[2:0];
      quo_q <= quo_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/calibrated_tick_debouncer_core.sv
`default_nettype none
// Calibrated tick debouncer. Items enter on the s_axis side (action in tuser) and every item
// returns exactly one result word on the m_axis side. Start, sample and interrupt items flow at
// one per cycle while the output is not stalled; each result passes through an input register
// and a result register, and a stalled output holds a waiting item in the input register, which
// then blocks the next item from entering. A calibration finish item launches an 8-step
// byte-serial divide by 40 of the timestamp delta, runs the 8 divide steps, and then refreshes
// the tick threshold; no further item is processed meanwhile. Configuration writes are
// taken in any cycle (cfg_ready_o is always high) and must only be issued while no result is
// pending.
`include "calibrated_tick_debouncer_core_assert.svh"
module calibrated_tick_debouncer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // stamp [63:0], counter_value [79:64], core_number [85:80]
  input  wire logic [87:0]                   s_axis_tdata,
  // action [1:0]
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // window_reached [0], eoi_only [1], tick_taken [2], stats_due [3], switch_due [4],
  // tick_value [36:5], rate_value [100:37]
  output logic [103:0]                       m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ctd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ctd_pkg::CfgDataW-1:0]  cfg_data_i
);

  ctd_pkg::state_e   state_q, state_d;

  logic              in_valid_q;
  ctd_pkg::in_data_t in_data_q;
  ctd_pkg::action_e  in_act_q;

  logic              out_valid_q;
  ctd_pkg::res_t     res_q, res_d, item_res, thr_res;

  logic [31:0]       target_q;
  logic [3:0]        gap_q;
  logic [63:0]       thresh_q;

  logic [31:0]       tick_q, tick_d;
  logic [7:0]        stats_cnt_q, stats_cnt_d;
  logic [63:0]       last_q, last_d;
  logic [63:0]       cpm_q;
  logic [63:0]       start_q, start_d;
  logic [15:0]       prev_q, prev_d;
  logic [31:0]       elapsed_q, elapsed_d;

  logic              out_free;
  logic              is_finish;
  logic              consume;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic              thr_load;
  logic [63:0]       div_num;
  logic [63:0]       div_quo;

  logic [16:0]       smp_delta;
  logic [32:0]       smp_sum;
  logic [31:0]       smp_elapsed;
  logic [63:0]       irq_gap;
  logic              stats_hit;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign is_finish = in_act_q == ctd_pkg::ACT_FINISH;

  assign s_axis_tready = !in_valid_q || consume;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign cfg_ready_o   = 1'b1;

  // per-item datapath
  always_comb begin
    tick_d      = tick_q;
    stats_cnt_d = stats_cnt_q;
    last_d      = last_q;
    start_d     = start_q;
    prev_d      = prev_q;
    elapsed_d   = elapsed_q;
    div_num     = in_data_q.stamp - start_q;
    irq_gap     = in_data_q.stamp - last_q;
    // tick count wrapping to zero is a multiple of 250 as well
    stats_hit   = (stats_cnt_q == ctd_pkg::StatsLast) || (tick_q == '1);

    // counter wraps when the reading is above the previous one
    if (in_data_q.counter_value > prev_q) begin
      smp_delta = 17'(prev_q) + 17'(ctd_pkg::CounterTop - in_data_q.counter_value);
    end else begin
      smp_delta = 17'(prev_q - in_data_q.counter_value);
    end
    smp_sum     = {1'b0, elapsed_q} + 33'(smp_delta);
    smp_elapsed = smp_sum[32] ? '1 : smp_sum[31:0];

    item_res            = '0;
    item_res.rate_value = cpm_q;
    item_res.tick_value = tick_q;

    unique case (in_act_q)
      ctd_pkg::ACT_START: begin
        start_d                 = in_data_q.stamp;
        prev_d                  = in_data_q.counter_value;
        elapsed_d               = '0;
        item_res.window_reached = target_q == '0;
      end
      ctd_pkg::ACT_SAMPLE: begin
        elapsed_d               = smp_elapsed;
        prev_d                  = in_data_q.counter_value;
        item_res.window_reached = smp_elapsed >= target_q;
      end
      ctd_pkg::ACT_FINISH: begin
      end
      ctd_pkg::ACT_IRQ: begin
        if (in_data_q.core_number != '0) begin
          item_res.eoi_only = 1'b1;
        end else if (irq_gap >= thresh_q) begin
          last_d              = in_data_q.stamp;
          tick_d              = tick_q + 32'd1;
          stats_cnt_d         = stats_hit ? '0 : stats_cnt_q + 8'd1;
          item_res.tick_taken = 1'b1;
          item_res.stats_due  = stats_hit;
          // new count is even when the old one was odd
          item_res.switch_due = tick_q[0];
          item_res.tick_value = tick_d;
        end
      end
      default: begin
      end
    endcase

    thr_res            = '0;
    thr_res.rate_value = cpm_q;
    thr_res.tick_value = tick_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctd_pkg::ST_RUN: begin
        if (in_valid_q && is_finish) begin
          state_d = ctd_pkg::ST_DIV;
        end
      end
      ctd_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = ctd_pkg::ST_THR;
        end
      end
      ctd_pkg::ST_THR: begin
        if (out_free) begin
          state_d = ctd_pkg::ST_RUN;
        end
      end
      default: state_d = ctd_pkg::ST_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    consume   = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    thr_load  = 1'b0;
    res_d     = item_res;
    unique case (state_q)
      ctd_pkg::ST_RUN: begin
        consume   = in_valid_q && (is_finish || out_free);
        out_load  = in_valid_q && !is_finish && out_free;
        div_start = in_valid_q && is_finish;
      end
      ctd_pkg::ST_DIV: begin
      end
      ctd_pkg::ST_THR: begin
        thr_load = out_free;
        out_load = out_free;
        res_d    = thr_res;
      end
      default: begin
      end
    endcase
  end

  ctd_div40 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctd_pkg::ST_RUN;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_act_q  <= ctd_pkg::action_e'(s_axis_tuser);
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= ctd_pkg::TargetReset;
      gap_q       <= ctd_pkg::GapReset;
      thresh_q    <= '0;
      tick_q      <= '0;
      stats_cnt_q <= '0;
      last_q      <= '0;
      cpm_q       <= '0;
      start_q     <= '0;
      prev_q      <= '0;
      elapsed_q   <= '0;
    end else begin
      if (consume) begin
        tick_q      <= tick_d;
        stats_cnt_q <= stats_cnt_d;
        last_q      <= last_d;
        start_q     <= start_d;
        prev_q      <= prev_d;
        elapsed_q   <= elapsed_d;
      end
      if (div_done) begin
        cpm_q <= (div_quo == '0) ? 64'd1 : div_quo;
      end
      if (cfg_valid_i && (cfg_index_i == ctd_pkg::CFG_GAP_MS)) begin
        thresh_q <= ctd_pkg::sat_mul_gap(cpm_q, cfg_data_i[3:0]);
      end else if (thr_load) begin
        thresh_q <= ctd_pkg::sat_mul_gap(cpm_q, gap_q);
      end
      if (cfg_valid_i) begin
        priority if (cfg_index_i == ctd_pkg::CFG_TARGET_COUNTS) begin
          target_q <= cfg_data_i;
        end else if (cfg_index_i == ctd_pkg::CFG_GAP_MS) begin
          gap_q    <= cfg_data_i[3:0];
        end else begin
        end
      end
    end
  end

  `CTD_ASSERT(a_div_no_result, state_q == ctd_pkg::ST_DIV |-> !out_load)
  `CTD_ASSERT(a_thresh_sync, state_q == ctd_pkg::ST_RUN |-> thresh_q == ctd_pkg::sat_mul_gap(cpm_q, gap_q))
  `CTD_ASSERT(a_rate_nonzero, state_q == ctd_pkg::ST_THR |-> cpm_q != '0)
  `CTD_ASSERT(a_stats_range, stats_cnt_q < ctd_pkg::StatsPeriod)

endmodule
`default_nettype wire
